// File: rtl/core/vpa_pkg.sv
package vpa_pkg;

    localparam int MaxBlocks  = 64;
    localparam int IdxBits    = $clog2(MaxBlocks);
    localparam int CntBits    = $clog2(MaxBlocks + 1);
    localparam int AddrBits   = 16;
    localparam int OwnerBits  = 8;
    localparam int TagBits    = 16;
    localparam logic [15:0] DefaultTotal = 16'd1000;

    localparam int EntryBits = AddrBits + AddrBits + 1 + OwnerBits + TagBits;

    localparam logic [1:0] OpFirstFit = 2'd0;
    localparam logic [1:0] OpBestFit  = 2'd1;
    localparam logic [1:0] OpRelease  = 2'd2;
    localparam logic [1:0] OpSpare    = 2'd3;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOFIT   = 3'd1,
        ST_FULL    = 3'd2,
        ST_NOOWNER = 3'd3,
        ST_ZERO    = 3'd4
    } t_status;

    typedef struct packed {
        logic [AddrBits-1:0]  start;
        logic [AddrBits-1:0]  size;
        logic                 free;
        logic [OwnerBits-1:0] owner;
        logic [TagBits-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic                wr_en;
        logic [IdxBits-1:0]  wr_addr;
        t_entry              wr_data;
        logic [IdxBits-1:0]  rd_addr;
    } t_mem_req;

endpackage

// File: rtl/core/vpa_table.sv
module vpa_table
    import vpa_pkg::*;
(
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_entry   o_rd_data
);

    t_entry r_mem [MaxBlocks];
    t_entry r_rd;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        // write-first on the same entry
        if (i_req.wr_en && i_req.wr_addr == i_req.rd_addr) begin
            r_rd <= i_req.wr_data;
        end else begin
            r_rd <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

// File: rtl/core/vpa_ctrl.sv
module vpa_ctrl
    import vpa_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_operation,
    input  logic [7:0]           i_owner_id,
    input  logic [15:0]          i_request_size,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_status,
    output logic [15:0]          o_block_tag,
    output logic [15:0]          o_block_start,
    output logic [15:0]          o_free_units,
    output logic [6:0]           o_free_block_count,
    output t_mem_req             o_mem,
    input  t_entry               i_rd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DEC    = 9'b000000100,
        S_SHIFT  = 9'b000001000,
        S_SPLIT  = 9'b000010000,
        S_REL    = 9'b000100000,
        S_MERGE  = 9'b001000000,
        S_SUM    = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    t_state r_state, n_state;
    logic [CntBits-1:0] r_cnt, n_cnt;
    logic [15:0] r_tag_next, n_tag_next;
    logic [CntBits-1:0] r_i, n_i;
    logic r_rv, n_rv;
    logic [IdxBits-1:0] r_ri, n_ri;
    logic r_best, n_best;
    logic [OwnerBits-1:0] r_owner, n_owner;
    logic [15:0] r_need, n_need;
    logic r_found, n_found;
    logic [IdxBits-1:0] r_pick, n_pick;
    t_entry r_pe, n_pe;
    logic r_any, n_any;
    t_entry r_acc, n_acc;
    logic [CntBits-1:0] r_wp, n_wp;
    logic r_hv, n_hv;
    logic [2:0] r_st, n_st;
    logic [15:0] r_otag, n_otag, r_ostart, n_ostart;
    logic [15:0] r_units, n_units;
    logic [6:0] r_nf, n_nf;
    logic r_ov, n_ov;
    logic [2:0] r_ost, n_ost;
    logic [15:0] r_ot, n_ot, r_os, n_os, r_ou, n_ou;
    logic [6:0] r_on, n_on;
    logic r_init, n_init;
    logic [15:0] r_total, n_total;
    t_mem_req n_mem;

    logic out_free;
    t_entry e;

    assign out_free = !r_ov || !i_out_stall;
    assign o_cfg_ready = (r_state == S_IDLE) && !r_init;
    assign o_in_stall  = !((r_state == S_IDLE) && !r_init && !i_cfg_valid);

    always_comb begin
        n_state = r_state; n_cnt = r_cnt; n_tag_next = r_tag_next; n_i = r_i;
        n_rv = 1'b0; n_ri = r_ri; n_best = r_best;
        n_owner = r_owner; n_need = r_need; n_found = r_found; n_pick = r_pick;
        n_pe = r_pe; n_any = r_any; n_acc = r_acc; n_wp = r_wp; n_hv = r_hv;
        n_st = r_st; n_otag = r_otag; n_ostart = r_ostart; n_units = r_units;
        n_nf = r_nf; n_ov = r_ov; n_ost = r_ost; n_ot = r_ot; n_os = r_os;
        n_ou = r_ou; n_on = r_on; n_init = 1'b0; n_total = r_total;
        n_mem = '0;
        e = i_rd;
        if (r_ov && !i_out_stall) n_ov = 1'b0;
        if (r_init) begin
            n_mem.wr_en = 1'b1;
            n_mem.wr_data = '{start: '0, size: r_total, free: 1'b1, owner: '0, tag: '0};
            n_cnt = CntBits'(1);
            n_tag_next = 16'd1;
        end
        case (r_state)
            S_IDLE: begin
                if (i_cfg_valid && o_cfg_ready) begin
                    n_total = i_cfg_data;
                    n_init = 1'b1;
                end else if (i_in_valid && !o_in_stall) begin
                    n_owner = i_owner_id; n_need = i_request_size;
                    n_best = (i_operation == OpBestFit);
                    n_found = 1'b0; n_any = 1'b0; n_hv = 1'b0;
                    n_otag = '0; n_ostart = '0;
                    n_i = '0; n_wp = '0;
                    if (i_operation[1]) begin
                        n_state = S_REL;
                        n_mem.rd_addr = '0; n_rv = 1'b1; n_ri = '0; n_i = CntBits'(1);
                    end else if (i_request_size == '0) begin
                        n_st = ST_ZERO; n_state = S_SUM;
                        n_mem.rd_addr = '0; n_rv = 1'b1; n_ri = '0; n_i = CntBits'(1);
                        n_units = '0; n_nf = '0;
                    end else begin
                        n_state = S_SCAN;
                        n_mem.rd_addr = '0; n_rv = 1'b1; n_ri = '0; n_i = CntBits'(1);
                    end
                end
            end
            S_SCAN: begin
                if (r_rv) begin
                    if (e.free && e.size >= r_need &&
                        (!r_found || (r_best && e.size < r_pe.size))) begin
                        n_found = 1'b1; n_pick = r_ri; n_pe = e;
                    end
                end
                if (r_i < r_cnt && !(n_found && !r_best)) begin
                    n_mem.rd_addr = r_i[IdxBits-1:0]; n_rv = 1'b1;
                    n_ri = r_i[IdxBits-1:0]; n_i = r_i + 1'b1;
                end else if (!r_rv || r_i >= r_cnt || (n_found && !r_best)) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (!r_found) begin
                    n_st = ST_NOFIT; n_state = S_SUM;
                end else if (r_pe.size != r_need && r_cnt >= CntBits'(MaxBlocks)) begin
                    n_st = ST_FULL; n_state = S_SUM;
                end else if (r_pe.size == r_need) begin
                    n_mem.wr_en = 1'b1; n_mem.wr_addr = r_pick;
                    n_mem.wr_data = r_pe;
                    n_mem.wr_data.free = 1'b0; n_mem.wr_data.owner = r_owner;
                    n_st = ST_OK; n_otag = r_pe.tag; n_ostart = r_pe.start;
                    n_state = S_SUM;
                end else begin
                    n_i = r_cnt;
                    n_state = S_SHIFT;
                end
                if (n_state == S_SUM) begin
                    n_units = '0; n_nf = '0;
                    n_mem.rd_addr = '0; n_rv = 1'b1; n_i = CntBits'(1);
                end
            end
            S_SHIFT: begin
                // move entry i-1 to i, downward from count to pick+2
                if (r_rv) begin
                    n_mem.wr_en = 1'b1; n_mem.wr_addr = r_wp[IdxBits-1:0];
                    n_mem.wr_data = e;
                end
                if (r_i > CntBits'(r_pick) + CntBits'(1)) begin
                    n_mem.rd_addr = IdxBits'(r_i - 1'b1); n_rv = 1'b1;
                    n_wp = r_i; n_i = r_i - 1'b1;
                end else if (!r_rv) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                if (!r_hv) begin
                    n_mem.wr_en = 1'b1; n_mem.wr_addr = r_pick + 1'b1;
                    n_mem.wr_data = '{start: r_pe.start + r_need,
                                      size: r_pe.size - r_need, free: 1'b1,
                                      owner: '0, tag: r_tag_next};
                    n_hv = 1'b1;
                end else begin
                    n_mem.wr_en = 1'b1; n_mem.wr_addr = r_pick;
                    n_mem.wr_data = '{start: r_pe.start, size: r_need, free: 1'b0,
                                      owner: r_owner, tag: r_pe.tag};
                    n_tag_next = r_tag_next + 1'b1;
                    n_cnt = r_cnt + 1'b1;
                    n_st = ST_OK; n_otag = r_pe.tag; n_ostart = r_pe.start;
                    n_units = '0; n_nf = '0;
                    n_mem.rd_addr = '0; n_rv = 1'b1; n_i = CntBits'(1);
                    n_state = S_SUM;
                end
            end
            S_REL: begin
                if (r_rv) begin
                    if (!e.free && e.owner == r_owner) begin
                        n_any = 1'b1;
                        n_mem.wr_en = 1'b1; n_mem.wr_addr = r_ri;
                        n_mem.wr_data = e;
                        n_mem.wr_data.free = 1'b1; n_mem.wr_data.owner = '0;
                    end
                end
                if (r_i < r_cnt) begin
                    n_mem.rd_addr = r_i[IdxBits-1:0]; n_rv = 1'b1;
                    n_ri = r_i[IdxBits-1:0]; n_i = r_i + 1'b1;
                end else if (!r_rv) begin
                    if (n_any) begin
                        n_state = S_MERGE; n_hv = 1'b0; n_wp = '0;
                        n_mem.rd_addr = '0; n_rv = 1'b1; n_i = CntBits'(1);
                    end else begin
                        n_st = ST_NOOWNER; n_state = S_SUM;
                        n_units = '0; n_nf = '0;
                        n_mem.rd_addr = '0; n_rv = 1'b1; n_i = CntBits'(1);
                    end
                end
            end
            S_MERGE: begin
                // compaction: r_acc holds the pending entry, r_wp the write slot
                if (r_rv) begin
                    if (r_hv && r_acc.free && e.free) begin
                        n_acc.size = r_acc.size + e.size;
                    end else begin
                        if (r_hv) begin
                            n_mem.wr_en = 1'b1; n_mem.wr_addr = r_wp[IdxBits-1:0];
                            n_mem.wr_data = r_acc; n_wp = r_wp + 1'b1;
                        end
                        n_acc = e; n_hv = 1'b1;
                    end
                end
                if (r_i < r_cnt) begin
                    n_mem.rd_addr = r_i[IdxBits-1:0]; n_rv = 1'b1; n_i = r_i + 1'b1;
                end else if (!r_rv) begin
                    n_mem.wr_en = 1'b1; n_mem.wr_addr = r_wp[IdxBits-1:0];
                    n_mem.wr_data = r_acc;
                    n_cnt = r_wp + 1'b1;
                    n_st = ST_OK; n_state = S_SUM;
                    n_units = '0; n_nf = '0;
                    n_mem.rd_addr = '0; n_rv = 1'b1; n_i = CntBits'(1);
                end
            end
            S_SUM: begin
                if (r_rv && e.free) begin
                    n_units = r_units + e.size; n_nf = r_nf + 1'b1;
                end
                if (r_i < r_cnt) begin
                    n_mem.rd_addr = r_i[IdxBits-1:0]; n_rv = 1'b1; n_i = r_i + 1'b1;
                end else if (!r_rv) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_ov = 1'b1; n_ost = r_st; n_ot = r_otag; n_os = r_ostart;
                    n_ou = r_units; n_on = r_nf; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_init) n_mem.wr_addr = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_cnt <= CntBits'(1); r_tag_next <= 16'd1;
            r_rv <= 1'b0; r_ov <= 1'b0; r_init <= 1'b1; r_total <= DefaultTotal;
            r_hv <= 1'b0;
        end else begin
            r_state <= n_state; r_cnt <= n_cnt; r_tag_next <= n_tag_next;
            r_rv <= n_rv; r_ov <= n_ov; r_init <= n_init; r_total <= n_total;
            r_hv <= n_hv;
        end
        r_i <= n_i; r_ri <= n_ri; r_best <= n_best;
        r_owner <= n_owner; r_need <= n_need; r_found <= n_found; r_pick <= n_pick;
        r_pe <= n_pe; r_any <= n_any; r_acc <= n_acc; r_wp <= n_wp;
        r_st <= n_st; r_otag <= n_otag; r_ostart <= n_ostart; r_units <= n_units;
        r_nf <= n_nf; r_ost <= n_ost; r_ot <= n_ot; r_os <= n_os; r_ou <= n_ou;
        r_on <= n_on;
    end

    assign o_mem = n_mem;
    assign o_out_valid = r_ov;
    assign o_status = r_ost;
    assign o_block_tag = r_ot;
    assign o_block_start = r_os;
    assign o_free_units = r_ou;
    assign o_free_block_count = r_on;

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CntBits'(1) && r_cnt <= CntBits'(MaxBlocks))
        else $error("entry count out of range");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && !r_init) |-> !o_mem.wr_en)
        else $error("table written while idle");
    a_ok_alloc_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ost == ST_ZERO) |-> (r_ot == '0 && r_os == '0))
        else $error("zero-size result carries block fields");
`endif

endmodule

// File: rtl/core/variable_partition_allocator.sv
// channel | direction | handshake         | payload
// cfg     | in        | valid / ready     | total size
// in      | in        | valid / stall     | operation, owner_id, request_size
// out     | out       | valid / stall     | status, block_tag, block_start,
//         |           |                   | free_units, free_block_count
// One transaction at a time; from acceptance to a valid result it runs a scan and insert
// shift, or a release and merge pass, then a totals pass over one read port. Input stays
// stalled until the result is registered.
// Reset and a total size write rebuild entry zero.
// The result register holds while the out channel is stalled.
module variable_partition_allocator
    import vpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_owner_id,
    input  logic [15:0] i_request_size,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_block_tag,
    output logic [15:0] o_block_start,
    output logic [15:0] o_free_units,
    output logic [6:0]  o_free_block_count
);

    t_mem_req mem;
    t_entry   rd;

    vpa_table u_table (.i_clk(i_clk), .i_req(mem), .o_rd_data(rd));

    vpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_operation(i_operation), .i_owner_id(i_owner_id),
        .i_request_size(i_request_size),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_status(o_status), .o_block_tag(o_block_tag), .o_block_start(o_block_start),
        .o_free_units(o_free_units), .o_free_block_count(o_free_block_count),
        .o_mem(mem), .i_rd(rd)
    );

endmodule
